[rtl/bfifo_pkg.sv]
`timescale 1ns / 1ps

package bfifo_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_BURST_DEF   = 64;

  localparam int CMD_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 11;
  localparam int OFFSET_W  = 10;
  localparam int PATTERN_W = 64;
  localparam int PLEN_W    = 4;
  localparam int AMOUNT_W  = 11;
  localparam int FILL_W    = 11;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_SKIP = 3'd2,
    CMD_PEEK = 3'd3,
    CMD_FIND = 3'd4
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STREAM,
    S_FIND
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [BYTE_W-1:0]    push_byte;
    logic [COUNT_W-1:0]   count;
    logic [OFFSET_W-1:0]  offset;
    logic [PATTERN_W-1:0] pattern;
    logic [PLEN_W-1:0]    pattern_length;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_out;
    logic                byte_valid;
    logic                last;
    logic [AMOUNT_W-1:0] amount;
    logic [FILL_W-1:0]   fill_level;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

[rtl/byte_fifo_with_peek_and_search.sv]
// Push, skip and commands that emit no byte give their one beat in the cycle after accept.
// Pop and peek: one read in flight; the FSM enters the stream state, reads a byte into rd_data
// and loads it into the output register before the next read (single read port).
// Find: scans one stored byte per cycle.
// Throughput: one push or skip per cycle while the result beat is taken; the byte store is written only while idle.
// Reset: synchronous; pointers and fill count clear at once, the byte store is not cleared.
`timescale 1ns / 1ps

module byte_fifo_with_peek_and_search #(
  parameter int DEPTH       = bfifo_pkg::DEPTH_DEF,
  parameter int MAX_PATTERN = bfifo_pkg::MAX_PATTERN_DEF,
  parameter int MAX_BURST   = bfifo_pkg::MAX_BURST_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bfifo_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output bfifo_pkg::rsp_t  rsp
);

  import bfifo_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int HW = $clog2(DEPTH + 1);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int CW = (HW > COUNT_W) ? HW : COUNT_W;
  localparam int SW = CW + 1;

  state_t state, state_next;

  logic [BYTE_W-1:0] byte_store [DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [PW-1:0]     raddr, raddr_inc;
  logic [PW-1:0]     rptr, wptr, wptr_inc;
  logic [HW-1:0]     held;
  logic [BW-1:0]     remain;
  logic [HW-1:0]     issued, seen;
  logic              dv, chk;

  logic [BYTE_W-1:0]      win  [MAX_PATTERN];
  logic [BYTE_W-1:0]      apat [MAX_PATTERN];
  logic [BYTE_W-1:0]      apat_c [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] amask, amask_c;
  logic [PLEN_W-1:0]      plen_r, plen_sat;

  logic acc, rd_en, wr_en, issue_s, issue_f;
  logic load_imm, load_s, find_done, hit, find_last, mism;
  logic full, empty, stream_go, find_now, imm;

  logic [CW-1:0] held_c, count_c, start_c, avail_c, burst_c, n_c, skip_c, adv_c, find_amt;
  logic [SW-1:0] base_sum, adv_sum;
  logic [PW-1:0] base_c, adv_ptr;
  rsp_t          rsp_imm;

  assign held_c   = CW'(held);
  assign count_c  = CW'(req.count);
  assign start_c  = (req.command == CMD_PEEK) ? CW'(req.offset) : '0;
  assign avail_c  = (held_c > start_c) ? held_c - start_c : '0;
  assign burst_c  = (count_c > CW'(MAX_BURST)) ? CW'(MAX_BURST) : count_c;
  assign n_c      = (burst_c > avail_c) ? avail_c : burst_c;
  assign skip_c   = (count_c > held_c) ? held_c : count_c;
  assign adv_c    = (req.command == CMD_POP)  ? n_c :
                    (req.command == CMD_SKIP) ? skip_c : '0;

  assign base_sum = SW'(rptr) + SW'(start_c);
  assign base_c   = (base_sum >= SW'(DEPTH)) ? PW'(base_sum - SW'(DEPTH)) : PW'(base_sum);
  assign adv_sum  = SW'(rptr) + SW'(adv_c);
  assign adv_ptr  = (adv_sum >= SW'(DEPTH)) ? PW'(adv_sum - SW'(DEPTH)) : PW'(adv_sum);

  assign raddr_inc = (raddr == PW'(DEPTH - 1)) ? '0 : raddr + PW'(1);
  assign wptr_inc  = (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);

  assign plen_sat  = (req.pattern_length > PLEN_W'(MAX_PATTERN)) ?
                     PLEN_W'(MAX_PATTERN) : req.pattern_length;

  assign full      = (held == HW'(DEPTH));
  assign empty     = (held == '0);
  assign stream_go = ((req.command == CMD_POP) || (req.command == CMD_PEEK)) && (n_c != '0);
  assign find_now  = (plen_sat == '0) || (CW'(plen_sat) > held_c);
  assign imm       = !(stream_go || ((req.command == CMD_FIND) && !find_now));

  always_comb begin
    logic [PLEN_W-1:0] idx;
    idx = '0;
    for (int d = 0; d < MAX_PATTERN; d++) begin
      amask_c[d] = (PLEN_W'(d) < plen_sat);
      idx        = plen_sat - PLEN_W'(d) - PLEN_W'(1);
      apat_c[d]  = req.pattern[{idx[2:0], 3'b000} +: BYTE_W];
    end
  end

  always_comb begin
    mism = 1'b0;
    for (int d = 0; d < MAX_PATTERN; d++) begin
      if (amask[d] && (win[d] != apat[d])) begin
        mism = 1'b1;
      end
    end
  end

  assign hit       = chk && !mism && (CW'(seen) >= CW'(plen_r));
  assign find_last = chk && (seen == held);
  assign find_amt  = hit ? CW'(seen) - CW'(plen_r) : held_c;

  // handshake and sequencing strobes
  always_comb begin
    req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
    acc       = req_valid && req_ready;
    load_imm  = acc && imm;
    wr_en     = acc && (req.command == CMD_PUSH) && !full;
    find_done = (state == S_FIND) && (hit || find_last);
    issue_s   = (state == S_STREAM) && !dv && (!rsp_valid || rsp_ready);
    issue_f   = (state == S_FIND) && (issued != held) && !find_done;
    rd_en     = issue_s || issue_f;
    load_s    = (state == S_STREAM) && dv;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && stream_go) begin
          state_next = S_STREAM;
        end else if (acc && (req.command == CMD_FIND) && !find_now) begin
          state_next = S_FIND;
        end
      end
      S_STREAM: begin
        if (load_s && (remain == BW'(1))) begin
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        if (find_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_imm            = '0;
    rsp_imm.last       = 1'b1;
    rsp_imm.fill_level = FILL_W'(held);
    rsp_imm.status     = empty ? ST_EMPTY : ST_OK;
    case (req.command)
      CMD_PUSH: begin
        rsp_imm.status     = full ? ST_FULL : ST_OK;
        rsp_imm.fill_level = full ? FILL_W'(held) : FILL_W'(held_c + CW'(1));
      end
      CMD_POP: begin
        rsp_imm.fill_level = FILL_W'(held_c - n_c);
      end
      CMD_SKIP: begin
        rsp_imm.amount     = AMOUNT_W'(skip_c);
        rsp_imm.fill_level = FILL_W'(held_c - skip_c);
      end
      CMD_PEEK: begin
        rsp_imm.fill_level = FILL_W'(held);
      end
      CMD_FIND: begin
        rsp_imm.amount = AMOUNT_W'(held_c);
      end
      default: begin
        rsp_imm.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr      <= '0;
      wptr      <= '0;
      held      <= '0;
      rsp_valid <= 1'b0;
      dv        <= 1'b0;
      chk       <= 1'b0;
      remain    <= '0;
      issued    <= '0;
      seen      <= '0;
    end else begin
      dv  <= rd_en;
      chk <= (state == S_FIND) && dv;
      if (load_imm || load_s || find_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (acc) begin
        remain <= BW'(n_c);
        issued <= '0;
        seen   <= '0;
        if (wr_en) begin
          wptr <= wptr_inc;
          held <= held + HW'(1);
        end else if ((req.command == CMD_POP) || (req.command == CMD_SKIP)) begin
          rptr <= adv_ptr;
          held <= held - HW'(adv_c);
        end
      end else begin
        if (load_s) begin
          remain <= remain - BW'(1);
        end
        if (issue_f) begin
          issued <= issued + HW'(1);
        end
        if ((state == S_FIND) && dv) begin
          seen <= seen + HW'(1);
        end
      end
    end
  end

  // byte store: reads and writes never share a cycle, the FSM only reads outside idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store[wptr] <= req.push_byte;
    end
    if (rd_en) begin
      rd_data <= byte_store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      raddr  <= (req.command == CMD_FIND) ? rptr : base_c;
      plen_r <= plen_sat;
      amask  <= amask_c;
      apat   <= apat_c;
    end else if (rd_en) begin
      raddr <= raddr_inc;
    end
    if ((state == S_FIND) && dv) begin
      win[0] <= rd_data;
      for (int d = 1; d < MAX_PATTERN; d++) begin
        win[d] <= win[d-1];
      end
    end
    if (load_imm) begin
      rsp <= rsp_imm;
    end else if (load_s) begin
      rsp.data_out   <= rd_data;
      rsp.byte_valid <= 1'b1;
      rsp.last       <= (remain == BW'(1));
      rsp.amount     <= '0;
      rsp.fill_level <= FILL_W'(held);
      rsp.status     <= ST_OK;
    end else if (find_done) begin
      rsp.data_out   <= '0;
      rsp.byte_valid <= 1'b0;
      rsp.last       <= 1'b1;
      rsp.amount     <= AMOUNT_W'(find_amt);
      rsp.fill_level <= FILL_W'(held);
      rsp.status     <= ST_OK;
    end
  end

endmodule

[rtl/bfifo_chk.sv]
`timescale 1ns / 1ps

module bfifo_chk #(
  parameter int DEPTH = bfifo_pkg::DEPTH_DEF
) (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input bfifo_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input bfifo_pkg::rsp_t rsp
);

  import bfifo_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_burst_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> !req_ready)
    else $error("new command taken inside a burst");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.byte_valid |-> rsp.status == ST_OK && rsp.amount == '0)
    else $error("data beat with bad status or amount");

  a_push_resp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.command == CMD_PUSH) |=>
      rsp_valid && rsp.last && !rsp.byte_valid)
    else $error("push result missing");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.fill_level) <= DEPTH)
    else $error("fill level beyond depth");

endmodule

bind byte_fifo_with_peek_and_search bfifo_chk #(.DEPTH(DEPTH)) u_bfifo_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[tb/sv/bfifo_scoreboard.sv]
`timescale 1ns / 1ps

module bfifo_scoreboard
  import bfifo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int DEPTH = DEPTH_DEF;

  logic [BYTE_W-1:0] shadow [DEPTH];
  int head;
  int tail;
  int held;
  rsp_t due_beats [$];
  rsp_t want;

  function automatic void check_field(string name, logic [10:0] exp_val, logic [10:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  task automatic run_command(input req_t r);
    rsp_t beat;
    logic [BYTE_W-1:0] burst [MAX_BURST_DEF];
    int start;
    int avail;
    int emit;
    int n;
    int plen;
    int hit;
    bit same;
    beat = '0;
    beat.last = 1'b1;
    beat.status = (held == 0) ? ST_EMPTY : ST_OK;
    emit = 0;
    case (r.command)
      CMD_PUSH: begin
        beat.status = ST_OK;
        if (held >= DEPTH) begin
          beat.status = ST_FULL;
        end else begin
          shadow[tail] = r.push_byte;
          tail = (tail + 1) % DEPTH;
          held++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        start = (r.command == CMD_PEEK) ? int'(r.offset) : 0;
        avail = (held > start) ? held - start : 0;
        emit = (r.count > MAX_BURST_DEF) ? MAX_BURST_DEF : int'(r.count);
        if (emit > avail) emit = avail;
        for (int i = 0; i < emit; i++) burst[i] = shadow[(head + start + i) % DEPTH];
        if (r.command == CMD_POP) begin
          head = (head + emit) % DEPTH;
          held -= emit;
        end
      end
      CMD_SKIP: begin
        n = (int'(r.count) < held) ? int'(r.count) : held;
        head = (head + n) % DEPTH;
        held -= n;
        beat.amount = AMOUNT_W'(n);
      end
      CMD_FIND: begin
        plen = (r.pattern_length > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(r.pattern_length);
        hit = held;
        if (plen > 0) begin
          for (int i = 0; i + plen <= held && hit == held; i++) begin
            same = 1'b1;
            for (int j = 0; j < plen; j++)
              if (shadow[(head + i + j) % DEPTH] != r.pattern[8*j +: 8]) same = 1'b0;
            if (same) hit = i;
          end
        end
        beat.amount = AMOUNT_W'(hit);
      end
      default: beat.status = ST_OK;
    endcase
    beat.fill_level = FILL_W'(held);
    if (emit == 0) begin
      due_beats.push_back(beat);
    end else begin
      for (int i = 0; i < emit; i++) begin
        beat.data_out = burst[i];
        beat.byte_valid = 1'b1;
        beat.last = (i == emit - 1);
        due_beats.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      tail = 0;
      held = 0;
      mismatches = 0;
      due_beats.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_beats.size() == 0) begin
          $error("beat with nothing expected: data_out %0d, fill_level %0d",
                 rsp.data_out, rsp.fill_level);
          mismatches++;
        end else begin
          want = due_beats.pop_front();
          check_field("data_out", 11'(want.data_out), 11'(rsp.data_out));
          check_field("byte_valid", 11'(want.byte_valid), 11'(rsp.byte_valid));
          check_field("last", 11'(want.last), 11'(rsp.last));
          check_field("amount", want.amount, rsp.amount);
          check_field("fill_level", want.fill_level, rsp.fill_level);
          check_field("status", 11'(want.status), 11'(rsp.status));
        end
      end
      if (req_valid && req_ready) run_command(req);
    end
    outstanding = due_beats.size();
  end

endmodule

[tb/sv/tb_byte_fifo_with_peek_and_search.sv]
`timescale 1ns / 1ps

module tb_byte_fifo_with_peek_and_search;
  import bfifo_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic steady = 1'b0;
  int mismatches;
  int outstanding;

  always #5 clk = ~clk;

  always @(negedge clk) rsp_ready <= steady || ($urandom_range(99) >= 11);

  byte_fifo_with_peek_and_search uut (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp
  );

  bfifo_scoreboard scoreboard (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp,
    .mismatches,
    .outstanding
  );

  function automatic req_t scramble_req(logic [CMD_W-1:0] cmd);
    req_t r;
    r.command = cmd;
    r.push_byte = BYTE_W'($urandom);
    r.count = COUNT_W'($urandom_range(1024, 0));
    r.offset = OFFSET_W'($urandom);
    r.pattern = {$urandom, $urandom};
    r.pattern_length = PLEN_W'($urandom);
    return r;
  endfunction

  task automatic issue(input req_t r);
    if (!steady && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [COUNT_W-1:0] cnt,
                          logic [OFFSET_W-1:0] off, logic [PATTERN_W-1:0] pat,
                          logic [PLEN_W-1:0] plen, logic [BYTE_W-1:0] data);
    req_t r;
    r.command = cmd;
    r.push_byte = data;
    r.count = cnt;
    r.offset = off;
    r.pattern = pat;
    r.pattern_length = plen;
    issue(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic random_item();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    r = scramble_req(CMD_W'($urandom_range(7, 0)));
    if (pick < 55) begin
      r.command = CMD_PUSH;
      if ($urandom_range(99) < 80) r.push_byte = BYTE_W'($urandom_range(3, 0));
    end else if (pick < 65) begin
      r.command = CMD_POP;
      if ($urandom_range(99) < 90) r.count = COUNT_W'($urandom_range(6, 0));
    end else if (pick < 71) begin
      r.command = CMD_SKIP;
      if ($urandom_range(99) < 90) r.count = COUNT_W'($urandom_range(4, 0));
    end else if (pick < 82) begin
      r.command = CMD_PEEK;
      if ($urandom_range(99) < 90) begin
        r.offset = OFFSET_W'($urandom_range(40, 0));
        r.count = COUNT_W'($urandom_range(16, 0));
      end
    end else if (pick < 95) begin
      r.command = CMD_FIND;
      if ($urandom_range(99) < 85) begin
        r.pattern_length = PLEN_W'($urandom_range(3, 1));
        for (int j = 0; j < 8; j++) r.pattern[8*j +: 8] = BYTE_W'($urandom_range(3, 0));
      end
    end
    issue(r);
  endtask

  initial begin : stimulus
    req_t r;
    logic [23:0] recent;
    recent = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(CMD_POP, 5, 0, '0, 0, 0);
    send_cmd(CMD_SKIP, 3, 0, '0, 0, 0);
    send_cmd(CMD_PEEK, 2, 0, '0, 0, 0);
    send_cmd(CMD_FIND, 0, 0, 64'h0201, 2, 0);
    for (int c = CMD_FIND + 1; c < 8; c++) send_cmd(CMD_W'(c), 1024, 1023, '1, 15, 8'hFF);
    send_cmd(CMD_PUSH, 0, 0, '0, 0, 8'h00);
    send_cmd(CMD_PUSH, 0, 0, '0, 0, 8'hFF);
    send_cmd(CMD_PUSH, 0, 0, '0, 0, 8'hA5);
    send_cmd(CMD_PUSH, 0, 0, '0, 0, 8'h5A);
    send_cmd(CMD_PEEK, 2, 1, '0, 0, 0);
    send_cmd(CMD_PEEK, 1, 4, '0, 0, 0);
    send_cmd(CMD_PEEK, 1024, 1023, '0, 0, 0);
    send_cmd(CMD_FIND, 0, 0, 64'h00FF, 0, 0);
    send_cmd(CMD_FIND, 0, 0, 64'hA5FF, 2, 0);
    send_cmd(CMD_FIND, 0, 0, 64'hFEDC_BA98_7654_3210, 15, 0);
    send_cmd(CMD_FIND, 0, 0, 64'h5AA5_FF00, 4, 0);
    send_cmd(CMD_POP, 0, 0, '0, 0, 0);
    send_cmd(CMD_POP, 1, 0, '0, 0, 0);
    send_cmd(CMD_SKIP, 1, 0, '0, 0, 0);
    send_cmd(CMD_POP, 1024, 0, '0, 0, 0);
    send_cmd(CMD_SKIP, 1024, 0, '0, 0, 0);
    drain();

    for (int i = 0; i < DEPTH_DEF; i++) begin
      r = scramble_req(CMD_PUSH);
      recent = {r.push_byte, recent[23:8]};
      issue(r);
    end
    send_cmd(CMD_PUSH, 0, 0, '0, 0, 8'h3C);
    send_cmd(CMD_PUSH, 0, 0, '0, 0, 8'hC3);
    send_cmd(CMD_PEEK, 64, 1023, '0, 0, 0);
    send_cmd(CMD_PEEK, 1024, 960, '0, 0, 0);
    send_cmd(CMD_FIND, 0, 0, {40'd0, recent}, 3, 0);
    send_cmd(CMD_POP, 1024, 0, '0, 0, 0);
    send_cmd(CMD_SKIP, 1024, 0, '0, 0, 0);
    drain();

    for (int i = 0; i < 470; i++) begin
      if (i == 150) steady <= 1'b1;
      if (i == 230) steady <= 1'b0;
      if (i == 320) drain();
      random_item();
    end
    drain();
    repeat (40) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/bfifo_pkg.sv
rtl/byte_fifo_with_peek_and_search.sv
rtl/bfifo_chk.sv
tb/sv/bfifo_scoreboard.sv
tb/sv/tb_byte_fifo_with_peek_and_search.sv
